// ----- src/smpq_pkg.sv -----
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the sorted min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned VALUE_W         = 32;

    typedef enum logic [1:0] {
        ACT_PEEK  = 2'd0,
        ACT_PUSH  = 2'd1,
        ACT_POP   = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_HOLD = 1'b1
    } t_state;

    typedef struct packed {
        logic exec;
    } t_cmd;

endpackage

// ----- src/smpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// smpq_ctrl
// Transaction controller: takes one item, holds its result until taken.
// ----------------------------------------------------------------------------
module smpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output smpq_pkg::t_cmd o_cmd
);
    import smpq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd.exec  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.exec = i_in_valid;
            end
            ST_HOLD: begin
                o_out_valid = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ----- src/smpq_dp.sv -----
// ----------------------------------------------------------------------------
// smpq_dp
// Sorted store: a row of cells with parallel compare-and-shift, plus flags.
// ----------------------------------------------------------------------------
module smpq_dp #(
    parameter int unsigned QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  smpq_pkg::t_cmd                     i_cmd,
    input  logic [1:0]                         i_action,
    input  logic signed [smpq_pkg::VALUE_W-1:0] i_value,
    output logic signed [smpq_pkg::VALUE_W-1:0] o_top_value,
    output logic [CNT_W-1:0]                   o_entry_count,
    output logic                               o_is_empty,
    output logic                               o_empty_read_error,
    output logic                               o_overflow
);
    import smpq_pkg::*;

    logic signed [VALUE_W-1:0] r_entries [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] n_entries [QUEUE_DEPTH];
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_err;
    logic                      r_ovf;
    logic                      n_err;
    logic                      n_ovf;
    logic                      wr_en;
    logic                      full;
    logic                      empty;
    logic [QUEUE_DEPTH-1:0]    gt;
    t_action                   act;

    assign act   = t_action'(i_action);
    assign full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty = (r_count == '0);

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        // insertion point lies at or before this cell
        assign gt[g] = (CNT_W'(g) >= r_count) || (i_value < r_entries[g]);

        always_comb begin
            n_entries[g] = r_entries[g];
            if (act == ACT_PUSH) begin
                if (gt[g]) begin
                    if (g == 0) begin
                        n_entries[g] = i_value;
                    end else if (!gt[(g == 0) ? 0 : g - 1]) begin
                        n_entries[g] = i_value;
                    end else begin
                        n_entries[g] = r_entries[(g == 0) ? 0 : g - 1];
                    end
                end
            end else begin
                n_entries[g] = r_entries[(g == QUEUE_DEPTH - 1) ? g : g + 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_entries[g] <= n_entries[g];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_err   = 1'b0;
        n_ovf   = 1'b0;
        wr_en   = 1'b0;
        unique case (act)
            ACT_PEEK: begin
                n_err = empty;
            end
            ACT_PUSH: begin
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    wr_en   = i_cmd.exec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_POP: begin
                if (!empty) begin
                    wr_en   = i_cmd.exec;
                    n_count = r_count - CNT_W'(1);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_err <= n_err;
            r_ovf <= n_ovf;
        end
    end

    assign o_top_value        = empty ? '0 : r_entries[0];
    assign o_entry_count      = r_count;
    assign o_is_empty         = empty;
    assign o_empty_read_error = r_err;
    assign o_overflow         = r_ovf;

endmodule

// ----- src/sorted_min_priority_queue_core.sv -----
// Latency: result valid on the cycle after the input transaction.
// Flow: the single result register must be taken before the next item
// is accepted.
// Reset: count cleared to zero; stored entries are not cleared and no
// clearing pass runs, so the block accepts an item straight after reset.
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_core
// Bounded min-priority queue keeping signed Q16.16 values in ascending order.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_core #(
    parameter int unsigned QUEUE_DEPTH = smpq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_action,
    input  logic signed [smpq_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [smpq_pkg::VALUE_W-1:0] o_top_value,
    output logic [CNT_W-1:0]                   o_entry_count,
    output logic                               o_is_empty,
    output logic                               o_empty_read_error,
    output logic                               o_overflow
);
    import smpq_pkg::*;

    t_cmd cmd;

    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    smpq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_action           (i_action),
        .i_value            (i_value),
        .o_top_value        (o_top_value),
        .o_entry_count      (o_entry_count),
        .o_is_empty         (o_is_empty),
        .o_empty_read_error (o_empty_read_error),
        .o_overflow         (o_overflow)
    );

`ifndef NO_ASSERTIONS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    a_no_accept_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result is pending");

    a_overflow_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> (o_entry_count == CNT_W'(QUEUE_DEPTH)))
        else $error("overflow flagged with store not full");

    a_read_error_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_read_error) |-> o_is_empty)
        else $error("empty read flagged with entries stored");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond depth");
`endif

endmodule
